FILE: design/pfr_pkg.sv
// Shared constants and types for the pose frame receiver.
// No dependencies; imported by every module of the block.
package pfr_pkg;

   localparam int PAYLOAD_BYTES = 24;
   localparam int WORD_BITS     = 32;
   localparam int WORD_COUNT    = 6;
   localparam int ANGLE_COUNT   = 3;
   localparam int RSP_BITS      = WORD_COUNT * WORD_BITS;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [1:0] CSR_TAIL_FIRST    = 2'd2;
   localparam logic [1:0] CSR_TAIL_SECOND   = 2'd3;

   localparam logic [7:0] RST_HEADER_FIRST  = 8'd13;
   localparam logic [7:0] RST_HEADER_SECOND = 8'd10;
   localparam logic [7:0] RST_TAIL_FIRST    = 8'd10;
   localparam logic [7:0] RST_TAIL_SECOND   = 8'd13;

   // 0.01745 as a double: 53-bit significand, value = SCALE_MANT * 2^-58
   localparam logic [52:0] SCALE_MANT = 53'h11DE69AD42C3CA;
   localparam logic [31:0] SCALE_LO   = SCALE_MANT[31:0];
   localparam logic [20:0] SCALE_HI   = SCALE_MANT[52:32];

   // Frame parser phases
   typedef enum logic [4:0] {
      PH_HUNT  = 5'b00001,
      PH_HEAD2 = 5'b00010,
      PH_DATA  = 5'b00100,
      PH_TAIL1 = 5'b01000,
      PH_TAIL2 = 5'b10000
   } phase_type;

endpackage

FILE: design/pose_frame_receiver_core.sv
// Pose frame receiver: byte-stream frame parser with angle scaling.
// After the second tail byte, a result passes the word, scaling and output registers.
// Throughput: one byte per cycle; req_tready drops only for a second tail byte
// while the previous result is still in the scaling pipeline or output register.
// Reset (synchronous, active high) restores the registers, the hunt phase and
// clears all valids; the payload store is left as is.
// Depends on pfr_pkg and pfr_angle_scale.
module pose_frame_receiver_core
   import pfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input bytes
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] rx_byte
   // results
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [31:0] z_angle_rad, [63:32] x_angle_rad, [95:64] y_angle_rad,
   // [127:96] x_position, [159:128] y_position, [191:160] yaw_rate
   output logic [RSP_BITS-1:0] rsp_tdata,
   // configuration
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic [7:0] header_first_ff, header_second_ff, tail_first_ff, tail_second_ff;
   logic       csr_write;

   // Write registers on the access cycle
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= RST_HEADER_FIRST;
         header_second_ff <= RST_HEADER_SECOND;
         tail_first_ff    <= RST_TAIL_FIRST;
         tail_second_ff   <= RST_TAIL_SECOND;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_HEADER_FIRST:  header_first_ff  <= csr_pwdata[7:0];
            CSR_HEADER_SECOND: header_second_ff <= csr_pwdata[7:0];
            CSR_TAIL_FIRST:    tail_first_ff    <= csr_pwdata[7:0];
            CSR_TAIL_SECOND:   tail_second_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_HEADER_FIRST:  csr_prdata = {24'd0, header_first_ff};
         CSR_HEADER_SECOND: csr_prdata = {24'd0, header_second_ff};
         CSR_TAIL_FIRST:    csr_prdata = {24'd0, tail_first_ff};
         CSR_TAIL_SECOND:   csr_prdata = {24'd0, tail_second_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Parser state
   phase_type  phase_ff, phase_in;
   logic [4:0] count_ff, count_in;
   logic [7:0] store_ff [PAYLOAD_BYTES];
   logic       byte_take, frame_done;
   logic [4:0] vld_ff;
   logic       out_valid_ff, out_valid_in;
   logic       busy;

   assign busy       = (|vld_ff) | out_valid_ff;
   assign req_tready = !(phase_ff == PH_TAIL2 && busy);
   assign byte_take  = req_tvalid & req_tready;
   assign frame_done = byte_take && phase_ff == PH_TAIL2 && req_tdata == tail_second_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (byte_take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_tdata == header_first_ff) phase_in = PH_HEAD2;
            end
            PH_HEAD2: begin
               if (req_tdata == header_second_ff) begin
                  phase_in = PH_DATA;
                  count_in = 5'd0;
               end else if (req_tdata != header_first_ff) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               if (count_ff == 5'(PAYLOAD_BYTES - 1)) begin
                  phase_in = PH_TAIL1;
                  count_in = 5'd0;
               end else begin
                  count_in = count_ff + 5'd1;
               end
            end
            PH_TAIL1: phase_in = (req_tdata == tail_first_ff) ? PH_TAIL2 : PH_HUNT;
            PH_TAIL2: phase_in = PH_HUNT;
            default:  phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= 5'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Shift payload bytes in; the first byte ends up at entry 0
   always_ff @(posedge clock) begin
      if (byte_take && phase_ff == PH_DATA) begin
         for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
            store_ff[i] <= store_ff[i + 1];
         end
         store_ff[PAYLOAD_BYTES - 1] <= req_tdata;
      end
   end

   // Capture the six words at the end of a good frame
   logic [WORD_BITS-1:0] word_ff [WORD_COUNT];

   always_ff @(posedge clock) begin
      if (frame_done) begin
         for (int k = 0; k < WORD_COUNT; k++) begin
            word_ff[k] <= {store_ff[4*k+3], store_ff[4*k+2], store_ff[4*k+1], store_ff[4*k]};
         end
      end
   end

   // Scale the angle words
   logic [WORD_BITS-1:0] angle_out [ANGLE_COUNT];

   for (genvar g = 0; g < ANGLE_COUNT; g++) begin : g_angle
      pfr_angle_scale u_scale (
         .clock    (clock),
         .word_in  (word_ff[g]),
         .word_out (angle_out[g])
      );
   end

   // Track the result through the pipeline and hold it until taken
   assign out_valid_in = vld_ff[4] | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[3:0], frame_done};
         out_valid_ff <= out_valid_in;
      end
   end

   logic [RSP_BITS-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (vld_ff[4]) begin
         rsp_data_ff <= {word_ff[5], word_ff[4], word_ff[3],
                         angle_out[2], angle_out[1], angle_out[0]};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: design/pfr_angle_scale.sv
// Four-stage single-precision multiply by 0.01745, product rounded to double
// and then to single (nearest, ties to even). Uses pfr_pkg.
module pfr_angle_scale
   import pfr_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] word_in,
   output logic [31:0] word_out
);

   // Stage 1: unpack, normalize subnormals, flag special values
   logic              s1_sign_ff, s1_sign_in;
   logic              s1_spec_ff, s1_spec_in;
   logic [31:0]       s1_sval_ff, s1_sval_in;
   logic [23:0]       s1_mant_ff, s1_mant_in;
   logic signed [9:0] s1_exp_ff, s1_exp_in;

   always_comb begin
      logic [7:0]  e;
      logic [22:0] f;
      logic [4:0]  pos;
      logic [4:0]  sh;
      e   = word_in[30:23];
      f   = word_in[22:0];
      pos = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (f[i]) begin
            pos = 5'(i);
         end
      end
      sh = 5'd23 - pos;
      s1_sign_in = word_in[31];
      s1_spec_in = (e == 8'hFF) || (word_in[30:0] == 31'd0);
      if (e == 8'hFF && f != 23'd0) begin
         s1_sval_in = word_in | 32'h0040_0000;
      end else begin
         s1_sval_in = word_in;
      end
      if (e != 8'd0) begin
         s1_mant_in = {1'b1, f};
         s1_exp_in  = $signed({2'b00, e}) - 10'sd127;
      end else begin
         s1_mant_in = {1'b0, f} << sh;
         s1_exp_in  = -10'sd126 - $signed({5'd0, sh});
      end
   end

   // Stage 2: two partial products of the significand
   logic              s2_sign_ff, s2_spec_ff;
   logic [31:0]       s2_sval_ff;
   logic signed [9:0] s2_exp_ff;
   logic [55:0]       s2_plo_ff, s2_plo_in;
   logic [44:0]       s2_phi_ff, s2_phi_in;

   assign s2_plo_in = 56'(s1_mant_ff) * 56'(SCALE_LO);
   assign s2_phi_in = 45'(s1_mant_ff) * 45'(SCALE_HI);

   // Stage 3: full 77-bit product
   logic              s3_sign_ff, s3_spec_ff;
   logic [31:0]       s3_sval_ff;
   logic signed [9:0] s3_exp_ff;
   logic [76:0]       s3_prod_ff, s3_prod_in;

   assign s3_prod_in = {s2_phi_ff, 32'd0} + 77'(s2_plo_ff);

   // Stage 4: round the product to a double significand
   logic              s4_sign_ff, s4_spec_ff;
   logic [31:0]       s4_sval_ff;
   logic signed [9:0] s4_exp_ff, s4_exp_in;
   logic [52:0]       s4_mant_ff, s4_mant_in;

   always_comb begin
      logic [76:0] pn;
      logic [53:0] dm;
      logic        inc;
      pn  = s3_prod_ff[76] ? s3_prod_ff : {s3_prod_ff[75:0], 1'b0};
      inc = pn[23] & ((|pn[22:0]) | pn[24]);
      dm  = {1'b0, pn[76:24]} + 54'(inc);
      s4_exp_in = s3_exp_ff - 10'sd6 + (s3_prod_ff[76] ? 10'sd1 : 10'sd0);
      if (dm[53]) begin
         s4_mant_in = dm[53:1];
         s4_exp_in  = s4_exp_in + 10'sd1;
      end else begin
         s4_mant_in = dm[52:0];
      end
   end

   // Advance the stages every cycle
   always_ff @(posedge clock) begin
      s1_sign_ff <= s1_sign_in;
      s1_spec_ff <= s1_spec_in;
      s1_sval_ff <= s1_sval_in;
      s1_mant_ff <= s1_mant_in;
      s1_exp_ff  <= s1_exp_in;
      s2_sign_ff <= s1_sign_ff;
      s2_spec_ff <= s1_spec_ff;
      s2_sval_ff <= s1_sval_ff;
      s2_exp_ff  <= s1_exp_ff;
      s2_plo_ff  <= s2_plo_in;
      s2_phi_ff  <= s2_phi_in;
      s3_sign_ff <= s2_sign_ff;
      s3_spec_ff <= s2_spec_ff;
      s3_sval_ff <= s2_sval_ff;
      s3_exp_ff  <= s2_exp_ff;
      s3_prod_ff <= s3_prod_in;
      s4_sign_ff <= s3_sign_ff;
      s4_spec_ff <= s3_spec_ff;
      s4_sval_ff <= s3_sval_ff;
      s4_exp_ff  <= s4_exp_in;
      s4_mant_ff <= s4_mant_in;
   end

   // Round the double to single; a carry out of the fraction bumps the exponent
   always_comb begin
      logic [30:0]       fld;
      logic              guard, sticky, inc;
      logic [116:0]      ext;
      logic signed [9:0] r;
      logic signed [9:0] be;
      be  = s4_exp_ff + 10'sd127;
      r   = -s4_exp_ff - 10'sd97;
      ext = {s4_mant_ff, 64'd0} >> r[5:0];
      if (s4_exp_ff >= -10'sd126) begin
         fld    = {be[7:0], s4_mant_ff[51:29]};
         guard  = s4_mant_ff[28];
         sticky = |s4_mant_ff[27:0];
      end else begin
         fld    = {8'd0, ext[86:64]};
         guard  = ext[63];
         sticky = |ext[62:0];
      end
      inc = guard & (sticky | fld[0]);
      if (s4_spec_ff) begin
         word_out = s4_sval_ff;
      end else begin
         word_out = {s4_sign_ff, fld + 31'(inc)};
      end
   end

endmodule

FILE: design/pfr_checker.sv
// Port-level checks for pose_frame_receiver_core, bound to the top level.
// Depends on pfr_pkg.
module pfr_checker
   import pfr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [7:0]          req_tdata,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                csr_psel,
   input logic                csr_penable,
   input logic                csr_pwrite,
   input logic [3:0]          csr_paddr,
   input logic [31:0]         csr_pwdata,
   input logic [31:0]         csr_prdata,
   input logic                csr_pready
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   // A new result follows an accepted byte by the pipeline latency
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 6))
      else $error("result word without a matching input byte");

   // No result straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input stalls only while a result is in flight or waiting
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tvalid |-> $past(req_tvalid && req_tready, 1) ||
         $past(req_tvalid && req_tready, 2) || $past(req_tvalid && req_tready, 3) ||
         $past(req_tvalid && req_tready, 4) || $past(req_tvalid && req_tready, 5))
      else $error("input stalled with no result pending");

endmodule

bind pose_frame_receiver_core pfr_checker u_pfr_checker (.*);

FILE: tb/tb_top.sv
// Testbench for pose_frame_receiver_core: directed and random byte streams,
// with a built-in frame parser and float scaler that predict every result.
// Depends on pfr_pkg and the pose_frame_receiver_core RTL.
module tb_top
   import pfr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   // Parser phases of the predictor
   typedef enum int {HUNT, HEAD2, DATA, TAIL1, TAIL2} hunt_phase_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [3:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   pose_frame_receiver_core u_dut (.*);

   always #6 clock = ~clock;

   // Predictor state and register copies
   logic [7:0]          hdr1 = RST_HEADER_FIRST, hdr2 = RST_HEADER_SECOND;
   logic [7:0]          tl1 = RST_TAIL_FIRST, tl2 = RST_TAIL_SECOND;
   hunt_phase_type      phase = HUNT;
   int                  pay_cnt = 0;
   logic [7:0]          pay_bytes [PAYLOAD_BYTES];
   logic [RSP_BITS-1:0] pose_queue [$];

   int  errors = 0;
   int  cycles = 0;
   int  burst_left = 0;
   bit  no_gaps = 0;
   bit  long_hold_req = 0;
   int  hold_left = 0;
   int  rx_mode = 0;

   // Single to double widening, exact except for NaN (widened to infinity), subnormals normalized
   function automatic logic [63:0] widen(logic [31:0] w);
      logic [23:0] m;
      int          ex;
      m = {1'b0, w[22:0]};
      if (w[30:23] == 8'hFF) return {w[31], 11'h7FF, 52'd0};
      if (w[30:0] == 31'd0) return {w[31], 63'd0};
      if (w[30:23] == 8'd0) begin
         ex = -126;
         while (!m[23]) begin
            m = m << 1;
            ex--;
         end
      end else begin
         ex = int'(w[30:23]) - 127;
      end
      return {w[31], 11'(ex + 1023), m[22:0], 29'd0};
   endfunction

   // Double to single, round to nearest even
   function automatic logic [31:0] narrow(logic [63:0] d);
      logic [63:0] sig, kept, rem, half, mag;
      int          es, sh;
      if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      es = int'(d[62:52]) - 1023 + 127;
      if (es >= 255) return {d[63], 8'hFF, 23'd0};
      sh = (es >= 1) ? 29 : 30 - es;
      if (sh > 60) return {d[63], 31'd0};
      sig  = {11'd0, 1'b1, d[51:0]};
      kept = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept++;
      mag = (es >= 1) ? (64'(es - 1) << 23) + kept : kept;
      return {d[63], mag[30:0]};
   endfunction

   function automatic logic [31:0] deg_to_rad(logic [31:0] w);
      real r;
      if (w[30:23] == 8'hFF && w[22:0] != 0) return w | 32'h0040_0000;
      r = $bitstoreal(widen(w)) * 0.01745;
      return narrow($realtobits(r));
   endfunction

   // Advance the frame parser by one byte; queue a pose on a good tail
   function automatic void parse_byte(logic [7:0] b);
      logic [RSP_BITS-1:0] pose;
      logic [31:0]         w;
      case (phase)
         HUNT: if (b == hdr1) phase = HEAD2;
         HEAD2: begin
            if (b == hdr2) begin
               phase = DATA;
               pay_cnt = 0;
            end else if (b != hdr1) begin
               phase = HUNT;
            end
         end
         DATA: begin
            pay_bytes[pay_cnt] = b;
            pay_cnt++;
            if (pay_cnt >= PAYLOAD_BYTES) begin
               pay_cnt = 0;
               phase = TAIL1;
            end
         end
         TAIL1: phase = (b == tl1) ? TAIL2 : HUNT;
         default: begin
            phase = HUNT;
            if (b == tl2) begin
               for (int k = 0; k < WORD_COUNT; k++) begin
                  w = {pay_bytes[4*k+3], pay_bytes[4*k+2], pay_bytes[4*k+1], pay_bytes[4*k]};
                  pose[k*WORD_BITS +: WORD_BITS] = (k < ANGLE_COUNT) ? deg_to_rad(w) : w;
               end
               pose_queue.push_back(pose);
            end
         end
      endcase
   endfunction

   // Track accepted bytes and check each accepted pose word
   always @(posedge clock) begin
      logic [RSP_BITS-1:0] want;
      string               names [WORD_COUNT];
      names = '{"z_angle_rad", "x_angle_rad", "y_angle_rad",
                "x_position", "y_position", "yaw_rate"};
      if (!reset) begin
         if (req_tvalid && req_tready) parse_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (pose_queue.size() == 0) begin
               $error("unexpected pose word %h", rsp_tdata);
               errors++;
            end else begin
               want = pose_queue.pop_front();
               for (int k = 0; k < WORD_COUNT; k++)
                  if (rsp_tdata[k*WORD_BITS +: WORD_BITS] !== want[k*WORD_BITS +: WORD_BITS]) begin
                     $error("%s: expected %h, got %h", names[k],
                            want[k*WORD_BITS +: WORD_BITS], rsp_tdata[k*WORD_BITS +: WORD_BITS]);
                     errors++;
                  end
            end
         end
      end
   end

   // Receiver stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      cycles++;
      if (cycles % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (long_hold_req) begin
         long_hold_req = 0;
         hold_left = 400;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Watchdog
   always @(posedge clock)
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end

   // Offer one byte, in bursts with random gaps, and hold until accepted
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every pose word has arrived
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pose_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      wait_drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom_range(0, 16777215)), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_HEADER_FIRST:  hdr1 = val;
         CSR_HEADER_SECOND: hdr2 = val;
         CSR_TAIL_FIRST:    tl1 = val;
         default:           tl2 = val;
      endcase
   endtask

   task automatic set_markers(input logic [7:0] a, b, c, d);
      csr_write(CSR_HEADER_FIRST, a);
      csr_write(CSR_HEADER_SECOND, b);
      csr_write(CSR_TAIL_FIRST, c);
      csr_write(CSR_TAIL_SECOND, d);
   endtask

   // Random float word, weighted toward special classes
   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0: w[30:23] = 8'hFF;
         1: w[30:23] = 8'h00;
         2: w[30:0]  = 31'd0;
         3: w[30:23] = 8'($urandom_range(250, 254));
         4: w[30:23] = 8'($urandom_range(1, 6));
         default: ;
      endcase
      return w;
   endfunction

   // Send one frame; bad selects 0 good, 1 bad first tail, 2 bad second tail
   task automatic send_frame(input logic [31:0] w [WORD_COUNT], input int bad);
      send_byte(hdr1);
      send_byte(hdr2);
      for (int k = 0; k < WORD_COUNT; k++)
         for (int j = 0; j < 4; j++) send_byte(w[k][8*j +: 8]);
      send_byte(bad == 1 ? tl1 ^ 8'h5A : tl1);
      send_byte(bad == 2 ? tl2 ^ 8'h81 : tl2);
   endtask

   task automatic random_frame(input int bad);
      logic [31:0] w [WORD_COUNT];
      foreach (w[k]) w[k] = pick_word();
      send_frame(w, bad);
   endtask

   task automatic test_special_words();
      logic [31:0] w [WORD_COUNT];
      w = '{32'h7FC0_0001, 32'hFF80_0000, 32'h0000_0001, 32'h0000_0000,
            32'hFFFF_FFFF, 32'h7F7F_FFFF};
      send_frame(w, 0);
      w = '{32'h7F80_0001, 32'h8000_0000, 32'h7F7F_FFFF, 32'h007F_FFFF,
            32'h8000_0001, 32'h3F80_0000};
      send_frame(w, 0);
      w = '{32'hFFBF_FFFF, 32'h807F_FFFF, 32'h0080_0000, 32'h1234_5678,
            32'h9ABC_DEF0, 32'h0000_0000};
      send_frame(w, 0);
      wait_drain();
   endtask

   task automatic test_broken_frames();
      // repeated first header, then a wrong second header, then tail faults
      send_byte(hdr1);
      send_byte(hdr1);
      send_byte(hdr1);
      send_byte(hdr1 ^ 8'h01 ^ ((hdr1 ^ 8'h01) == hdr2 ? 8'h02 : 8'h00));
      random_frame(1);
      random_frame(2);
      random_frame(0);
      wait_drain();
   endtask

   task automatic test_backpressure();
      no_gaps = 1;
      long_hold_req = 1;
      repeat (5) random_frame(0);
      no_gaps = 0;
      wait_drain();
   endtask

   task automatic test_random_stream(input int n_bytes);
      int sent, pick;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            random_frame(0);
            sent += 28;
         end else if (pick < 17) begin
            random_frame($urandom_range(1, 2));
            sent += 28;
         end else begin
            repeat ($urandom_range(1, 8)) begin
               send_byte($urandom_range(0, 3) == 0 ? hdr1 : 8'($urandom));
               sent++;
            end
         end
      end
      wait_drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_words();
      test_broken_frames();
      test_backpressure();
      test_random_stream(130);
      set_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
      test_random_stream(110);
      // equal header values: second-header check wins
      set_markers(8'hFF, 8'hFF, 8'h00, 8'hFF);
      test_broken_frames();
      test_random_stream(110);
      set_markers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      test_random_stream(110);
      set_markers(RST_HEADER_FIRST, RST_HEADER_SECOND, RST_TAIL_FIRST, RST_TAIL_SECOND);
      test_random_stream(110);
      wait_drain();
      if (errors == 0 && pose_queue.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
